### hw/rtl/totp_pkg.sv
// Package: shared types, constants and helper functions for the TOTP/HOTP engine.
package totp_pkg;

    localparam int KEY_WORDS = 8;
    localparam int KW_BITS   = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_HOTP   = 2'd1,
        OP_TOTP   = 2'd2,
        OP_VERIFY = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_STEP   = 2'd0,
        REG_DIGITS = 2'd1,
        REG_WINDOW = 2'd2,
        REG_KEYLEN = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  key_word_index;
        logic [63:0] key_word;
        logic [63:0] counter_value;
        logic signed [63:0] unix_time;
        logic [29:0] offered_code;
        logic [3:0]  offered_length;
    } in_item_t;

    typedef struct packed {
        logic [29:0] code_out;
        logic        match_found;
        logic [63:0] hit_counter;
    } out_item_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load_in;      // capture item
        logic div_start;    // start time division
        logic set_base;     // candidate <= item counter, or quotient (less window for verify)
        logic next_cand;    // advance candidate
        logic hmac_start;   // start HMAC of current counter
        logic mod_start;    // start modulo reduction
        logic clear_out;    // zero result fields
        logic set_code;     // put code into result
        logic set_match;    // record match
    } dp_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic div_done;
        logic hmac_done;
        logic mod_done;
        logic len_ok;
        logic cand_neg;
        logic cand_last;
        logic code_eq;
    } dp_stat_t;

    localparam logic [31:0] SHA_H0 = 32'h67452301;
    localparam logic [31:0] SHA_H1 = 32'hEFCDAB89;
    localparam logic [31:0] SHA_H2 = 32'h98BADCFE;
    localparam logic [31:0] SHA_H3 = 32'h10325476;
    localparam logic [31:0] SHA_H4 = 32'hC3D2E1F0;

    function automatic logic [31:0] pow10(input logic [3:0] d);
        logic [31:0] r;
        begin
            case (d)
                4'd1: r = 32'd10;
                4'd2: r = 32'd100;
                4'd3: r = 32'd1000;
                4'd4: r = 32'd10000;
                4'd5: r = 32'd100000;
                4'd6: r = 32'd1000000;
                4'd7: r = 32'd10000000;
                4'd8: r = 32'd100000000;
                default: r = 32'd1000000000;
            endcase
            return r;
        end
    endfunction

    function automatic logic [3:0] eff_digits(input logic [3:0] d);
        logic [3:0] r;
        begin
            if (d == 4'd0) r = 4'd1;
            else if (d > 4'd9) r = 4'd9;
            else r = d;
            return r;
        end
    endfunction

endpackage

### hw/rtl/totp_sha1_core.sv
// SHA-1 compression unit: one round per cycle with a 16-word schedule window.
module totp_sha1_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [159:0] h_in,
    input  logic [511:0] block,
    output logic         done,
    output logic [159:0] h_out
);
    import totp_pkg::*;

    logic [31:0]  w_reg   [16];
    logic [31:0]  w_next  [16];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [159:0] hs_reg;
    logic [6:0]   rnd_reg;
    logic         run_reg;
    logic         done_reg;
    logic [31:0]  f, k, t, wn;

    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = 32'h5A827999;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'h6ED9EBA1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = 32'h8F1BBCDC;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'hCA62C1D6;
        end
        t  = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + w_reg[0];
        wn = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        for (int i = 0; i < 15; i++)
        begin
            w_next[i] = w_reg[i + 1];
        end
        w_next[15] = {wn[30:0], wn[31]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                rnd_reg <= '0;
            end
            else if (run_reg)
            begin
                rnd_reg <= rnd_reg + 7'd1;
                if (rnd_reg == 7'd79)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= block[511 - 32 * i -: 32];
            end
            hs_reg <= h_in;
            a_reg  <= h_in[159:128];
            b_reg  <= h_in[127:96];
            c_reg  <= h_in[95:64];
            d_reg  <= h_in[63:32];
            e_reg  <= h_in[31:0];
        end
        else if (run_reg)
        begin
            w_reg <= w_next;
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= t;
        end
    end

    assign done  = done_reg;
    assign h_out = {hs_reg[159:128] + a_reg, hs_reg[127:96] + b_reg,
                    hs_reg[95:64] + c_reg, hs_reg[63:32] + d_reg, hs_reg[31:0] + e_reg};

`ifndef SYNTH
    a_done_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg) else $error("done while running");
    a_rnd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> rnd_reg < 7'd80) else $error("round overrun");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("done not a pulse");
`endif
endmodule

### hw/rtl/totp_hmac.sv
// HMAC-SHA1 over an 8-byte counter: four compressions through one SHA-1 core.
module totp_hmac (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [511:0] key_blk,
    input  logic [63:0]  counter,
    output logic         done,
    output logic [159:0] mac
);
    import totp_pkg::*;

    logic [1:0]   ph_reg;
    logic         run_reg;
    logic         done_reg;
    logic [159:0] hcur_reg;
    logic [159:0] inner_reg;
    logic         c_start;
    logic [159:0] c_hin;
    logic [511:0] c_blk;
    logic         c_done;
    logic [159:0] c_hout;
    logic [511:0] ipad, opad;

    assign ipad = key_blk ^ {64{8'h36}};
    assign opad = key_blk ^ {64{8'h5C}};

    always_comb
    begin
        case (ph_reg)
            2'd0:    c_blk = ipad;
            2'd1:    c_blk = {counter, 8'h80, 376'd0, 64'd576};
            2'd2:    c_blk = opad;
            default: c_blk = {inner_reg, 8'h80, 280'd0, 64'd672};
        endcase
        c_hin = (ph_reg == 2'd0 || ph_reg == 2'd2) ?
                {SHA_H0, SHA_H1, SHA_H2, SHA_H3, SHA_H4} : hcur_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            c_start  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            c_start  <= 1'b0;
            if (start)
            begin
                ph_reg  <= 2'd0;
                run_reg <= 1'b1;
                c_start <= 1'b1;
            end
            else if (run_reg && c_done)
            begin
                ph_reg <= ph_reg + 2'd1;
                if (ph_reg == 2'd3)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    c_start <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_done)
        begin
            hcur_reg <= c_hout;
            if (ph_reg == 2'd1)
            begin
                inner_reg <= c_hout;
            end
        end
    end

    totp_sha1_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (c_start),
        .h_in  (c_hin),
        .block (c_blk),
        .done  (c_done),
        .h_out (c_hout)
    );

    assign done = done_reg;
    assign mac  = hcur_reg;
endmodule

### hw/rtl/totp_datapath.sv
// Datapath: registers, key store, time divider, HMAC unit and modulo unit.
module totp_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  totp_pkg::in_item_t item_in,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  totp_pkg::dp_cmd_t  cmd,
    output totp_pkg::dp_stat_t stat,
    output totp_pkg::out_item_t result
);
    import totp_pkg::*;

    logic [30:0]  step_reg;
    logic [3:0]   digits_reg;
    logic [3:0]   window_reg;
    logic [6:0]   keylen_reg;
    logic [63:0]  key_reg [KEY_WORDS];
    in_item_t     it_reg;
    out_item_t    res_reg;

    // divider
    logic [63:0]  dq_reg, drem_reg;
    logic [6:0]   dcnt_reg;
    logic         drun_reg, ddone_reg, dneg_reg;
    logic [64:0]  dtrial;
    logic [63:0]  base;

    // candidates
    logic [63:0]  cand_reg;
    logic [4:0]   dleft_reg;

    // hmac
    logic [511:0] key_blk;
    logic         h_done;
    logic [159:0] mac;

    // modulo: restoring, 31-bit value by 30-bit modulus
    logic [30:0]  mval_reg;
    logic [30:0]  mrem_reg;
    logic [4:0]   mcnt_reg;
    logic         mrun_reg, mdone_reg;
    logic [31:0]  mtrial;
    logic [31:0]  modv;
    logic [3:0]   off;
    logic [30:0]  trunc;
    logic [159:0] macsh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= 31'd30;
            digits_reg <= 4'd6;
            window_reg <= 4'd1;
            keylen_reg <= 7'd20;
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_STEP:   step_reg   <= cfg_data;
                    REG_DIGITS: digits_reg <= cfg_data[3:0];
                    REG_WINDOW: window_reg <= cfg_data[3:0];
                    REG_KEYLEN: keylen_reg <= cfg_data[6:0];
                    default:    ;
                endcase
            end
            if (cmd.load_in && op_t'(item_in.op) == OP_LOAD &&
                {1'b0, item_in.key_word_index} < 4'(KEY_WORDS))
            begin
                key_reg[item_in.key_word_index[KW_BITS-1:0]] <= item_in.key_word;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 64; i++)
        begin
            if (i < KEY_WORDS * 8 && (7'(i) < keylen_reg || keylen_reg > 7'd64))
                key_blk[511 - 8 * i -: 8] = key_reg[i / 8][63 - 8 * (i % 8) -: 8];
            else
                key_blk[511 - 8 * i -: 8] = 8'h00;
        end
    end

    // time divider: |t| / step, one quotient bit per cycle
    assign dtrial = {drem_reg, dq_reg[63]} - {34'd0, (step_reg == 31'd0) ? 31'd1 : step_reg};
    assign base   = dneg_reg ? (~dq_reg + 64'd1) : dq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drun_reg  <= 1'b0;
            ddone_reg <= 1'b0;
            dcnt_reg  <= '0;
        end
        else
        begin
            ddone_reg <= 1'b0;
            if (cmd.div_start)
            begin
                drun_reg <= 1'b1;
                dcnt_reg <= '0;
            end
            else if (drun_reg)
            begin
                dcnt_reg <= dcnt_reg + 7'd1;
                if (dcnt_reg == 7'd63)
                begin
                    drun_reg  <= 1'b0;
                    ddone_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dneg_reg <= it_reg.unix_time[63];
            dq_reg   <= it_reg.unix_time[63] ? (~it_reg.unix_time + 64'd1) : it_reg.unix_time;
            drem_reg <= '0;
        end
        else if (drun_reg)
        begin
            if (!dtrial[64])
            begin
                drem_reg <= dtrial[63:0];
                dq_reg   <= {dq_reg[62:0], 1'b1};
            end
            else
            begin
                drem_reg <= {drem_reg[62:0], dq_reg[63]};
                dq_reg   <= {dq_reg[62:0], 1'b0};
            end
        end
    end

    // candidate counter
    always_ff @(posedge clk)
    begin
        if (cmd.set_base)
        begin
            case (op_t'(it_reg.op))
                OP_HOTP:   cand_reg <= it_reg.counter_value;
                OP_TOTP:   cand_reg <= base;
                default:   cand_reg <= base - {60'd0, window_reg};
            endcase
            dleft_reg <= {window_reg, 1'b0};
        end
        else if (cmd.next_cand)
        begin
            cand_reg  <= cand_reg + 64'd1;
            dleft_reg <= dleft_reg - 5'd1;
        end
    end

    totp_hmac u_hmac (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.hmac_start),
        .key_blk (key_blk),
        .counter (cand_reg),
        .done    (h_done),
        .mac     (mac)
    );

    assign off   = mac[3:0];
    assign macsh = mac << (8 * off);
    assign trunc = macsh[158:128];
    assign modv  = pow10(eff_digits(digits_reg));
    assign mtrial = {mrem_reg, mval_reg[30]} - modv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mrun_reg  <= 1'b0;
            mdone_reg <= 1'b0;
            mcnt_reg  <= '0;
        end
        else
        begin
            mdone_reg <= 1'b0;
            if (cmd.mod_start)
            begin
                mrun_reg <= 1'b1;
                mcnt_reg <= '0;
            end
            else if (mrun_reg)
            begin
                mcnt_reg <= mcnt_reg + 5'd1;
                if (mcnt_reg == 5'd30)
                begin
                    mrun_reg  <= 1'b0;
                    mdone_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mod_start)
        begin
            mval_reg <= trunc;
            mrem_reg <= '0;
        end
        else if (mrun_reg)
        begin
            mval_reg <= {mval_reg[29:0], 1'b0};
            if (!mtrial[31])
                mrem_reg <= mtrial[30:0];
            else
                mrem_reg <= {mrem_reg[29:0], mval_reg[30]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            it_reg <= item_in;
        end
        if (cmd.clear_out)
        begin
            res_reg <= '0;
        end
        else if (cmd.set_code)
        begin
            res_reg.code_out <= mrem_reg[29:0];
        end
        else if (cmd.set_match)
        begin
            res_reg.match_found <= 1'b1;
            res_reg.hit_counter <= cand_reg;
        end
    end

    assign stat.div_done  = ddone_reg;
    assign stat.hmac_done = h_done;
    assign stat.mod_done  = mdone_reg;
    assign stat.len_ok    = it_reg.offered_length == eff_digits(digits_reg);
    assign stat.cand_neg  = cand_reg[63];
    assign stat.cand_last = dleft_reg == 5'd0;
    assign stat.code_eq   = mrem_reg == {1'b0, it_reg.offered_code};
    assign result         = res_reg;
endmodule

### hw/rtl/totp_ctrl.sv
// Controller: sequences division, HMAC, modulo and the verify window.
module totp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         op,
    input  totp_pkg::dp_stat_t stat,
    output totp_pkg::dp_cmd_t  cmd,
    output logic               busy,
    output logic               done
);
    import totp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_DIV, S_BASE, S_CHECK, S_HMAC, S_MODS, S_MOD, S_EVAL, S_DONE
    } state_t;

    state_t    state_reg, state_next;
    dp_cmd_t   cmd_next;
    logic      busy_reg, busy_next;
    logic      done_reg, done_next;
    logic [1:0] op_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = '0;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next.load_in   = 1'b1;
                    cmd_next.clear_out = 1'b1;
                    busy_next          = 1'b1;
                    state_next         = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (op_t'(op_reg))
                    OP_LOAD:   state_next = S_DONE;
                    OP_HOTP:
                    begin
                        cmd_next.set_base = 1'b1;
                        state_next        = S_CHECK;
                    end
                    OP_TOTP:
                    begin
                        cmd_next.div_start = 1'b1;
                        state_next         = S_DIV;
                    end
                    default:
                    begin
                        if (stat.len_ok)
                        begin
                            cmd_next.div_start = 1'b1;
                            state_next         = S_DIV;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                cmd_next.set_base = 1'b1;
                state_next        = S_CHECK;
            end
            S_CHECK:
            begin
                if (op_t'(op_reg) == OP_VERIFY && stat.cand_neg)
                begin
                    if (stat.cand_last)
                        state_next = S_DONE;
                    else
                        cmd_next.next_cand = 1'b1;
                end
                else
                begin
                    cmd_next.hmac_start = 1'b1;
                    state_next          = S_HMAC;
                end
            end
            S_HMAC:
            begin
                if (stat.hmac_done)
                begin
                    state_next = S_MODS;
                end
            end
            S_MODS:
            begin
                cmd_next.mod_start = 1'b1;
                state_next         = S_MOD;
            end
            S_MOD:
            begin
                if (stat.mod_done)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (op_t'(op_reg) != OP_VERIFY)
                begin
                    cmd_next.set_code = 1'b1;
                    state_next        = S_DONE;
                end
                else if (stat.code_eq)
                begin
                    cmd_next.set_match = 1'b1;
                    state_next         = S_DONE;
                end
                else if (stat.cand_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd_next.next_cand = 1'b1;
                    state_next         = S_CHECK;
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            op_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            if (state_reg == S_IDLE && start)
            begin
                op_reg <= op;
            end
        end
    end

    assign cmd  = cmd_next;
    assign busy = busy_reg;
    assign done = done_reg;

`ifndef SYNTH
    a_idle_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !busy_reg) else $error("busy in idle");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE)) else $error("done outside idle");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> busy_reg) else $error("start not taken");
`endif
endmodule

### hw/rtl/totp_hotp_code_engine_unit.sv
// Top level: TOTP/HOTP code engine with HMAC-SHA1 and verify window.
//
// Usage: drive the input item on item_in and pulse start while busy is low;
// the item is taken at that edge and busy rises for the item's duration.
// One result per item appears on result, with done high for one cycle; the
// receiver cannot stall, so it must capture the result on that edge.
// Configuration: cfg_we with cfg_index (0 step, 1 digits, 2 window, 3 key
// length) and cfg_data, applied at the edge; the user must write only while idle.
// The block itself has no guard for this.
// Flow: HOTP runs the HMAC (four 80-round compressions on one SHA-1 core)
// and then the decimal reduction; TOTP and verify run the time division first.
// Verify repeats the code run for up to 2*window+1 counters, stopping at a
// match; a key load or a length mismatch skips the division and the HMAC.
// One item is processed at a time: start is taken only in the idle state.
// Reset clears the key store to zeros and loads register defaults
// (step 30, 6 digits, window 1, key length 20).
module totp_hotp_code_engine_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  totp_pkg::in_item_t  item_in,
    output logic                done,
    output totp_pkg::out_item_t result,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [30:0]         cfg_data
);
    import totp_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    totp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (item_in.op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    totp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (item_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );
endmodule

### tb/tb_totp_hotp_code_engine_unit.sv
// Testbench for the TOTP/HOTP code engine: directed table plus random checked items.
`timescale 1ns / 100ps

module tb_totp_hotp_code_engine_unit;
    import totp_pkg::*;

    localparam int WATCHDOG_CYCLES = 60000;
    localparam int N_PHASES = 12;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    item_in;
    logic        done;
    out_item_t   result;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [30:0] cfg_data;

    totp_hotp_code_engine_unit u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item_in(item_in),
        .done(done),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    typedef struct {
        in_item_t  it;
        bit        typed;
        out_item_t res;
    } row_t;

    logic [63:0] key_mem [0:KEY_WORDS-1];
    logic [30:0] m_step;
    logic [3:0]  m_digits;
    logic [3:0]  m_window;
    logic [6:0]  m_keylen;

    out_item_t pending_codes [$];
    int        err_cnt;
    int        quiet_cycles;
    bit        idle_en;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void sha1_block(inout logic [31:0] h [0:4],
                                       input logic [7:0] blk [0:127], input int base);
        logic [31:0] w [0:79];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[base+4*i], blk[base+4*i+1], blk[base+4*i+2], blk[base+4*i+3]};
        for (int i = 16; i < 80; i++)
            w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rotl(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rotl(b, 30); b = a; a = t;
        end
        h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
    endfunction

    // digest of a message of at most 119 bytes
    function automatic void sha1_msg(input logic [7:0] msg [0:127], input int len,
                                     output logic [7:0] dig [0:19]);
        logic [7:0]  blk [0:127];
        logic [31:0] h [0:4];
        logic [63:0] bits;
        int          nblk;
        h[0] = 32'h67452301; h[1] = 32'hEFCDAB89; h[2] = 32'h98BADCFE;
        h[3] = 32'h10325476; h[4] = 32'hC3D2E1F0;
        bits = len * 8;
        nblk = (len + 8) / 64 + 1;
        for (int i = 0; i < 128; i++)
            blk[i] = (i < len) ? msg[i] : 8'h00;
        blk[len] = 8'h80;
        for (int i = 0; i < 8; i++)
            blk[nblk*64-1-i] = bits[8*i +: 8];
        for (int i = 0; i < nblk; i++)
            sha1_block(h, blk, 64 * i);
        for (int i = 0; i < 20; i++)
            dig[i] = h[i/4] >> (24 - 8 * (i % 4));
    endfunction

    function automatic int digits_used();
        if (m_digits == 0)
            return 1;
        if (m_digits > 9)
            return 9;
        return m_digits;
    endfunction

    function automatic logic [29:0] otp_code(input logic [63:0] counter);
        logic [7:0]  kb [0:63];
        logic [7:0]  msg [0:127];
        logic [7:0]  inner [0:19];
        logic [7:0]  mac [0:19];
        logic [31:0] bin, modulus;
        int          len, off;
        len = (m_keylen > 64) ? 64 : m_keylen;
        for (int i = 0; i < 64; i++)
            kb[i] = (i < len) ? key_mem[i/8][8*(7-i%8) +: 8] : 8'h00;
        for (int i = 0; i < 128; i++)
            msg[i] = 8'h00;
        for (int i = 0; i < 64; i++)
            msg[i] = kb[i] ^ 8'h36;
        for (int i = 0; i < 8; i++)
            msg[64+i] = counter[8*(7-i) +: 8];
        sha1_msg(msg, 72, inner);
        for (int i = 0; i < 64; i++)
            msg[i] = kb[i] ^ 8'h5C;
        for (int i = 0; i < 20; i++)
            msg[64+i] = inner[i];
        sha1_msg(msg, 84, mac);
        off = mac[19] & 8'h0F;
        bin = {mac[off] & 8'h7F, mac[off+1], mac[off+2], mac[off+3]};
        modulus = 1;
        for (int i = 0; i < digits_used(); i++)
            modulus = modulus * 10;
        return bin % modulus;
    endfunction

    function automatic logic [63:0] step_counter(input logic signed [63:0] t);
        longint signed s;
        s = (m_step == 0) ? 1 : m_step;
        return t / s;
    endfunction

    function automatic out_item_t predict_code(input in_item_t it);
        out_item_t   r;
        logic [63:0] base, cand;
        r = '0;
        case (op_t'(it.op))
            OP_LOAD:
                if (it.key_word_index < KEY_WORDS)
                    key_mem[it.key_word_index] = it.key_word;
            OP_HOTP:
                r.code_out = otp_code(it.counter_value);
            OP_TOTP:
                r.code_out = otp_code(step_counter(it.unix_time));
            default:
                if (it.offered_length == digits_used())
                begin
                    base = step_counter(it.unix_time);
                    for (int d = 0; d <= 2 * m_window; d++)
                    begin
                        cand = base - m_window + d;
                        if (!cand[63] && otp_code(cand) == it.offered_code)
                        begin
                            r.match_found = 1'b1;
                            r.hit_counter = cand;
                            break;
                        end
                    end
                end
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        out_item_t want;
        if (done)
        begin
            if (pending_codes.size() == 0)
            begin
                $error("result with nothing pending");
                err_cnt++;
            end
            else
            begin
                want = pending_codes.pop_front();
                if (result.code_out !== want.code_out)
                begin
                    $error("code_out expected %0d actual %0d", want.code_out, result.code_out);
                    err_cnt++;
                end
                if (result.match_found !== want.match_found)
                begin
                    $error("match_found expected %0d actual %0d",
                           want.match_found, result.match_found);
                    err_cnt++;
                end
                if (result.hit_counter !== want.hit_counter)
                begin
                    $error("hit_counter expected %0h actual %0h",
                           want.hit_counter, result.hit_counter);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (done || (start && !busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_item(input in_item_t it, input bit typed, input out_item_t res);
        out_item_t want;
        if (idle_en && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 7)) @(negedge clk);
        while (busy)
            @(negedge clk);
        item_in <= it;
        start <= 1'b1;
        @(posedge clk);
        want = predict_code(it);
        pending_codes.push_back(typed ? res : want);
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [30:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_STEP:   m_step = val;
            REG_DIGITS: m_digits = val[3:0];
            REG_WINDOW: m_window = val[3:0];
            default:    m_keylen = val[6:0];
        endcase
        @(negedge clk);
    endtask

    task automatic drain();
        while (pending_codes.size() != 0 || busy)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_time();
        case ($urandom_range(0, 3))
            0: return rand64();
            1: return 64'sd0 + $signed($urandom_range(0, 400)) - 200;
            2: return 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 40);
            default: return {32'h0, $urandom};
        endcase
    endfunction

    function automatic in_item_t rand_item();
        in_item_t    it;
        logic [63:0] cand;
        int          span;
        it = '0;
        it.key_word_index = $urandom_range(0, 7);
        it.key_word = rand64();
        it.counter_value = ($urandom_range(0, 3) == 0) ? 64'(~$urandom_range(0, 20)) : rand64();
        it.unix_time = rand_time();
        it.offered_code = $urandom & 30'h3FFF_FFFF;
        it.offered_length = $urandom_range(0, 15);
        case ($urandom_range(0, 9))
            0, 1:    it.op = OP_LOAD;
            2, 3:    it.op = OP_HOTP;
            4, 5:    it.op = OP_TOTP;
            default: it.op = OP_VERIFY;
        endcase
        if (it.op == OP_VERIFY && $urandom_range(0, 9) < 7)
        begin
            it.offered_length = digits_used();
            span = m_window + 1;
            cand = step_counter(it.unix_time) + longint'($urandom_range(0, 2 * span)) - span;
            it.offered_code = cand[63] ? $urandom_range(0, 9) : otp_code(cand);
        end
        return it;
    endfunction

    row_t dir_rows [$];

    function automatic row_t mk_row(input op_t op, input logic [2:0] idx, input logic [63:0] kw,
                                    input logic [63:0] cnt, input logic [63:0] t,
                                    input logic [29:0] oc, input logic [3:0] ol,
                                    input bit typed, input logic [29:0] code,
                                    input logic fnd, input logic [63:0] mc);
        row_t r;
        r.it = '{op: op, key_word_index: idx, key_word: kw, counter_value: cnt,
                 unix_time: t, offered_code: oc, offered_length: ol};
        r.typed = typed;
        r.res = '{code_out: code, match_found: fnd, hit_counter: mc};
        return r;
    endfunction

    initial
    begin
        int          n_items;
        logic [30:0] p_step;
        logic [3:0]  p_dig, p_win;
        logic [6:0]  p_kb;
        rst_n = 1'b0;
        start = 1'b0;
        item_in = '0;
        cfg_we = 1'b0;
        cfg_index = REG_STEP;
        cfg_data = '0;
        err_cnt = 0;
        quiet_cycles = 0;
        idle_en = 1'b1;
        for (int i = 0; i < KEY_WORDS; i++)
            key_mem[i] = '0;
        m_step = 30; m_digits = 6; m_window = 1; m_keylen = 20;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset defaults, RFC 4226 test secret
        dir_rows.push_back(mk_row(OP_HOTP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_TOTP, 0, 0, 0, 64'h8000_0000_0000_0000, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_LOAD, 0, 64'h3132333435363738, 0, 0, 0, 0, 1, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_LOAD, 1, 64'h3930313233343536, 0, 0, 0, 0, 1, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_LOAD, 2, 64'h3738393000000000, 0, 0, 0, 0, 1, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_LOAD, 7, '1, 0, 0, 0, 0, 1, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_HOTP, 0, 0, 0, 0, 0, 0, 1, 755224, 0, 0));
        dir_rows.push_back(mk_row(OP_HOTP, 0, 0, 1, 0, 0, 0, 1, 287082, 0, 0));
        dir_rows.push_back(mk_row(OP_HOTP, 0, 0, '1, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_TOTP, 0, 0, 0, 59, 0, 0, 1, 287082, 0, 0));
        dir_rows.push_back(mk_row(OP_TOTP, 0, 0, 0, '1, 0, 0, 1, 755224, 0, 0));
        dir_rows.push_back(mk_row(OP_TOTP, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_VERIFY, 0, 0, 0, 59, 287082, 8, 1, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_VERIFY, 0, 0, 0, 59, 287082, 15, 1, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_VERIFY, 0, 0, 0, 59, 287082, 6, 1, 0, 1, 1));
        dir_rows.push_back(mk_row(OP_VERIFY, 0, 0, 0, 0, 755224, 6, 1, 0, 1, 0));
        dir_rows.push_back(mk_row(OP_VERIFY, 0, 0, 0, 59, 30'h3FFF_FFFF, 6, 1, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_VERIFY, 0, 0, 0, 64'h8000_0000_0000_0000, 123456, 6,
                                  0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_LOAD, 3, 64'hA5A5_5A5A_0F0F_F0F0, 0, 0, 0, 0, 1, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_VERIFY, 0, 0, 0, 60, 0, 6, 0, 0, 0, 0));
        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain();
            case (p)
                0: begin p_step = 1; p_dig = 9; p_win = 0; p_kb = 64; end
                1: begin p_step = 31'h7FFF_FFFF; p_dig = 1; p_win = 15; p_kb = 0; end
                2: begin p_step = 0; p_dig = 0; p_win = 2; p_kb = 127; end
                3: begin p_step = 60; p_dig = 15; p_win = 3; p_kb = 33; end
                N_PHASES - 1: begin p_step = 30; p_dig = 6; p_win = 1; p_kb = 20; end
                default:
                begin
                    p_step = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 120)
                                                         : ($urandom & 31'h7FFF_FFFF);
                    p_dig = $urandom_range(0, 15);
                    p_win = $urandom_range(0, 4);
                    p_kb = $urandom_range(0, 127);
                end
            endcase
            write_reg(REG_STEP, p_step);
            write_reg(REG_DIGITS, p_dig);
            write_reg(REG_WINDOW, p_win);
            write_reg(REG_KEYLEN, p_kb);
            idle_en = (p != N_PHASES - 1);
            n_items = (p_win > 4) ? 8 : 52;
            for (int i = 0; i < n_items; i++)
                send_item(rand_item(), 1'b0, '0);
        end

        while (pending_codes.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/totp_pkg.sv
hw/rtl/totp_sha1_core.sv
hw/rtl/totp_hmac.sv
hw/rtl/totp_datapath.sv
hw/rtl/totp_ctrl.sv
hw/rtl/totp_hotp_code_engine_unit.sv
tb/tb_totp_hotp_code_engine_unit.sv
